@@ design/dct_idct_8x8_core_defines.svh @@
// Assertion macros for the 8x8 DCT core.
`ifndef DCT_IDCT_8X8_CORE_DEFINES_SVH
`define DCT_IDCT_8X8_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define DCT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication outside reset.
`define DCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ design/dct_pkg.sv @@
// Package: constants, cosine table and command/status types for the DCT core.
`timescale 1ns / 1ps
package dct_pkg;
   localparam int SampleWidth = 12;
   localparam int CosFracBits = 14;
   localparam int PartWidth   = 29;
   localparam int AccWidth    = 48;
   localparam int ShiftBits   = 2 * CosFracBits + 2;

   typedef logic signed [CosFracBits+1:0] cos_type;

   // T[k][n] rounded to 14 fraction bits
   function automatic cos_type cos_lookup(input logic [2:0] k, input logic [2:0] n);
      logic [5:0] idx;
      cos_type v;
      idx = {k, n};
      case (k)
         3'd0: v = 16'sd11585;
         3'd1: case (n)
            3'd0: v = 16'sd16069; 3'd1: v = 16'sd13623; 3'd2: v = 16'sd9102;
            3'd3: v = 16'sd3196;  3'd4: v = -16'sd3196; 3'd5: v = -16'sd9102;
            3'd6: v = -16'sd13623; default: v = -16'sd16069;
         endcase
         3'd2: case (n)
            3'd0, 3'd7: v = 16'sd15137; 3'd1, 3'd6: v = 16'sd6270;
            3'd2, 3'd5: v = -16'sd6270; default: v = -16'sd15137;
         endcase
         3'd3: case (n)
            3'd0: v = 16'sd13623; 3'd1: v = -16'sd3196; 3'd2: v = -16'sd16069;
            3'd3: v = -16'sd9102; 3'd4: v = 16'sd9102;  3'd5: v = 16'sd16069;
            3'd6: v = 16'sd3196;  default: v = -16'sd13623;
         endcase
         3'd4: case (n)
            3'd0, 3'd3, 3'd4, 3'd7: v = 16'sd11585;
            default: v = -16'sd11585;
         endcase
         3'd5: case (n)
            3'd0: v = 16'sd9102;  3'd1: v = -16'sd16069; 3'd2: v = 16'sd3196;
            3'd3: v = 16'sd13623; 3'd4: v = -16'sd13623; 3'd5: v = -16'sd3196;
            3'd6: v = 16'sd16069; default: v = -16'sd9102;
         endcase
         3'd6: case (n)
            3'd0, 3'd7: v = 16'sd6270; 3'd1, 3'd6: v = -16'sd15137;
            3'd2, 3'd5: v = 16'sd15137; default: v = -16'sd6270;
         endcase
         default: case (n)
            3'd0: v = 16'sd3196;  3'd1: v = -16'sd9102; 3'd2: v = 16'sd13623;
            3'd3: v = -16'sd16069; 3'd4: v = 16'sd16069; 3'd5: v = -16'sd13623;
            3'd6: v = 16'sd9102;  default: v = -16'sd3196;
         endcase
      endcase
      if (idx == 6'd0) v = 16'sd11585;
      return v;
   endfunction

   typedef struct packed {
      logic       wr_sample;   // store incoming item
      logic [5:0] wr_addr;
      logic       pass;        // 0 row pass, 1 column pass
      logic       mac_clear;   // first term of a sum
      logic       mac_en;
      logic [2:0] a;
      logic [2:0] b;
      logic [2:0] t;
      logic       mac_done;    // last term issued: store or emit
      logic       direction;
   } cmd_type;

   typedef struct packed {
      logic       res_valid;
      logic       res_busy;
   } sts_type;
endpackage

@@ design/dct_stream_if.sv @@
// Valid/ready stream interfaces for the DCT core.
`timescale 1ns / 1ps
interface dct_req_if;
   logic valid;
   logic ready;
   logic signed [11:0] sample_value;
   modport source (output valid, output sample_value, input ready);
   modport sink (input valid, input sample_value, output ready);
endinterface

interface dct_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] result_value;
   logic [5:0] result_index;
   logic result_last;
   modport source (output valid, output result_value, output result_index,
                   output result_last, input ready);
   modport sink (input valid, input result_value, input result_index,
                 input result_last, output ready);
endinterface

@@ design/dct_datapath.sv @@
// Datapath: block and partial stores, shared MAC, rounding and output register.
`timescale 1ns / 1ps
module dct_datapath import dct_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic signed [11:0]     sample_in,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic signed [15:0]     rsp_value,
   output logic [5:0]             rsp_index,
   output logic                   rsp_last,
   output sts_type                sts
);
   logic signed [11:0]        block_mem [64];
   logic signed [PartWidth-1:0] part_mem [64];

   // stage 1: registered memory reads and coefficient
   logic signed [11:0]          blk_rd_ff;
   logic signed [PartWidth-1:0] part_rd_ff;
   cos_type                     coef_ff;
   logic                        s1_v_ff, s1_clr_ff, s1_done_ff, s1_pass_ff;
   logic [5:0]                  s1_dst_ff;
   // stage 2: product
   logic signed [AccWidth-1:0]  prod_ff;
   logic                        s2_v_ff, s2_clr_ff, s2_done_ff, s2_pass_ff;
   logic [5:0]                  s2_dst_ff;
   // stage 3: accumulator
   logic signed [AccWidth-1:0]  acc_ff, acc_in;
   logic                        s3_v_ff, s3_pass_ff;
   logic [5:0]                  s3_dst_ff;
   // output register
   logic                        out_v_ff;
   logic signed [15:0]          out_val_ff;
   logic [5:0]                  out_idx_ff;

   logic [2:0] ck, cn;
   logic [5:0] blk_addr, part_addr, dst;
   logic signed [AccWidth-1:0] mag_sum;
   logic [AccWidth-1:0] mag;
   logic [AccWidth-ShiftBits:0] rnd;
   logic signed [15:0] sat;

   always_comb begin
      // row: T[a][t]*x[t][b] (inverse T[t][a]); column: T[b][t] (inverse T[t][b])
      if (!cmd.pass) begin
         ck = cmd.direction ? cmd.t : cmd.a;
         cn = cmd.direction ? cmd.a : cmd.t;
      end else begin
         ck = cmd.direction ? cmd.t : cmd.b;
         cn = cmd.direction ? cmd.b : cmd.t;
      end
      blk_addr  = {cmd.t, cmd.b};
      part_addr = {cmd.a, cmd.t};
      dst       = {cmd.a, cmd.b};
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_sample) block_mem[cmd.wr_addr] <= sample_in;
      blk_rd_ff  <= block_mem[blk_addr];
      part_rd_ff <= part_mem[part_addr];
      coef_ff    <= cos_lookup(ck, cn);
      s1_clr_ff  <= cmd.mac_clear;
      s1_done_ff <= cmd.mac_done;
      s1_pass_ff <= cmd.pass;
      s1_dst_ff  <= dst;
      prod_ff    <= s1_pass_ff
                    ? AccWidth'(part_rd_ff * coef_ff)
                    : AccWidth'(blk_rd_ff * coef_ff);
      s2_clr_ff  <= s1_clr_ff;
      s2_done_ff <= s1_done_ff;
      s2_pass_ff <= s1_pass_ff;
      s2_dst_ff  <= s1_dst_ff;
      if (s2_v_ff) acc_ff <= acc_in;
      s3_pass_ff <= s2_pass_ff;
      s3_dst_ff  <= s2_dst_ff;
      if (s3_v_ff && !s3_pass_ff) part_mem[s3_dst_ff] <= PartWidth'(acc_ff);
      if (s3_v_ff && s3_pass_ff) begin
         out_val_ff <= sat;
         out_idx_ff <= s3_dst_ff;
      end
   end

   assign acc_in = s2_clr_ff ? prod_ff : acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.mac_en;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff && s2_done_ff;
         if (s3_v_ff && s3_pass_ff) out_v_ff <= 1'b1;
         else if (rsp_ready) out_v_ff <= 1'b0;
      end
   end

   // round half away from zero, saturate
   always_comb begin
      mag_sum = acc_ff;
      mag = mag_sum[AccWidth-1] ? AccWidth'(-mag_sum) : AccWidth'(mag_sum);
      rnd = (AccWidth-ShiftBits+1)'((mag + (AccWidth'(1) << (ShiftBits-1))) >> ShiftBits);
      if (mag_sum[AccWidth-1])
         sat = (rnd > 32768) ? -16'sd32768 : 16'(-rnd);
      else
         sat = (rnd > 32767) ? 16'sd32767 : 16'(rnd);
   end

   assign rsp_valid = out_v_ff;
   assign rsp_value = out_val_ff;
   assign rsp_index = out_idx_ff;
   assign rsp_last  = (out_idx_ff == 6'd63);
   assign sts       = '{res_valid: out_v_ff, res_busy: s1_v_ff | s2_v_ff | s3_v_ff};
endmodule

@@ design/dct_ctrl.sv @@
// Controller: collects the block and sequences the row and column passes.
`timescale 1ns / 1ps
module dct_ctrl import dct_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     direction,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     rsp_ready,
   input  sts_type  sts,
   output cmd_type  cmd
);
   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_ROW  = 2'd1;
   localparam logic [1:0] ST_DRN  = 2'd2;
   localparam logic [1:0] ST_COL  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [5:0] count_ff, count_in;
   logic [8:0] step_ff, step_in;     // {a, b, t}
   logic       dir_ff, dir_in;
   logic       issue, accept;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_LOAD);
   // column results leave through a single output register: issue the last
   // term of a sum only when that register is free as the result arrives
   assign issue = (state_ff == ST_ROW) ||
                  (state_ff == ST_COL && (step_ff[2:0] != 3'd7 ||
                   (!sts.res_valid || rsp_ready) && !sts.res_busy));

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      step_in  = step_ff;
      dir_in   = dir_ff;
      case (state_ff)
         ST_LOAD: if (accept) begin
            count_in = count_ff + 6'd1;
            if (count_ff == 6'd63) begin
               state_in = ST_ROW;
               step_in  = '0;
               dir_in   = direction;
            end
         end
         ST_ROW: begin
            step_in = step_ff + 9'd1;
            if (step_ff == 9'd511) state_in = ST_DRN;
         end
         ST_DRN: if (!sts.res_busy) state_in = ST_COL;
         ST_COL: if (issue) begin
            step_in = step_ff + 9'd1;
            if (step_ff == 9'd511) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         step_ff  <= '0;
         dir_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         step_ff  <= step_in;
         dir_ff   <= dir_in;
      end
   end

   always_comb begin
      cmd.wr_sample = accept;
      cmd.wr_addr   = count_ff;
      cmd.pass      = (state_ff == ST_COL);
      cmd.a         = step_ff[8:6];
      cmd.b         = step_ff[5:3];
      cmd.t         = step_ff[2:0];
      cmd.mac_en    = issue;
      cmd.mac_clear = (step_ff[2:0] == 3'd0);
      cmd.mac_done  = (step_ff[2:0] == 3'd7);
      cmd.direction = dir_ff;
   end
endmodule

@@ design/dct_idct_8x8_core.sv @@
// Top level: 8x8 forward/inverse DCT core with one shared multiply-accumulate.
//
//   channel  ports   dir  payload
//   request  req_*   in   sample_value (12b signed)
//   response rsp_*   out  result_value (16b s), result_index (6b), result_last
//   control  csr_*   in   direction (1b), write only
//
// An item is taken each cycle while the block is loading.
// After the 64th item one MAC runs 512 row steps, waits for the pipeline to
// drain, then runs 64 column sums (the closing term of a sum waits for the
// pipeline to empty); no new item is taken until the column pass ends.
// Reset is synchronous and active high; stores are left undefined.
// Hold the column pass while the output register waits on rsp.ready.
`timescale 1ns / 1ps
`include "dct_idct_8x8_core_defines.svh"
module dct_idct_8x8_core import dct_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   dct_req_if.sink       req,
   dct_rsp_if.source     rsp,
   input  logic          csr_we,
   input  logic          csr_wdata
);
   logic    direction_ff;
   cmd_type cmd;
   sts_type sts;

   // latch direction; the controller samples it when the last item of a block is taken
   always_ff @(posedge clock) begin
      if (reset) direction_ff <= 1'b0;
      else if (csr_we) direction_ff <= csr_wdata;
   end

   dct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .direction (direction_ff),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dct_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sample_in (req.sample_value),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .rsp_value (rsp.result_value),
      .rsp_index (rsp.result_index),
      .rsp_last  (rsp.result_last),
      .sts       (sts)
   );

   `DCT_ASSERT_IMPL(a_no_mac_while_loading, clock, reset, req.ready, !cmd.mac_en, "MAC step issued while loading")
   `DCT_ASSERT_IMPL(a_last_index, clock, reset, rsp.valid && rsp.result_last, rsp.result_index == 6'd63, "last flag off index 63")
   `DCT_ASSERT_NEXT(a_out_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.result_index) && $stable(rsp.result_value), "result dropped while stalled")
endmodule

@@ tb/dct_idct_8x8_core_test.sv @@
// Self-checking testbench for the 8x8 forward/inverse DCT core.
`timescale 1ns / 1ps
module dct_idct_8x8_core_test;

   localparam int WatchLimit = 20000;  // idle cycles allowed with work still open
   localparam int SettleCycles = 40;   // margin after the last result of a block

   typedef struct {
      logic signed [15:0] value;
      logic [5:0]         index;
      logic               last;
   } coef_item_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   dct_req_if req_if ();
   dct_rsp_if rsp_if ();

   dct_idct_8x8_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Samples waiting to go out, and transformed values still owed by the core.
   logic signed [11:0] sample_queue[$];
   coef_item_type      coef_queue[$];

   // Private copy of the core state used for prediction.
   logic signed [11:0] block_mem[64];
   int unsigned        fill_count;
   logic               inverse_mode;

   int  gap_left;
   int  stall_left;
   bit  idle_enable;
   int  fail_count;
   int  blocks_done;
   int  results_seen;
   int  quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Fixed-point cosine table entry T[k][n], 14 fraction bits.
   function automatic longint cos_coef(input int k, input int n);
      int mag[9];
      int m;
      mag = '{16384, 16069, 15137, 13623, 11585, 9102, 6270, 3196, 0};
      if (k == 0) begin
         return mag[4];
      end
      m = ((2 * n + 1) * k) % 32;
      if (m > 16) m = 32 - m;
      if (m > 8) return -mag[16 - m];
      return mag[m];
   endfunction

   // Scale by 2^-30, round half away from zero, clamp to 16 bits.
   function automatic logic signed [15:0] scale_round(input longint sum);
      longint mag;
      longint r;
      mag = (sum < 0) ? -sum : sum;
      r = (mag + (64'sd1 <<< 29)) >>> 30;
      if (sum < 0) return (r > 32768) ? -16'sd32768 : 16'(-r);
      return (r > 32767) ? 16'sd32767 : 16'(r);
   endfunction

   // Queue one sample at the tail of the pending list.
   function automatic void add_sample(input logic signed [11:0] s);
      sample_queue.insert(sample_queue.size(), s);
   endfunction

   // Store one accepted sample; on the 64th, work out the whole block.
   function automatic void take_sample(input logic signed [11:0] s);
      longint part[64];
      longint acc;
      coef_item_type c;
      block_mem[fill_count] = s;
      if (fill_count < 63) begin
         fill_count++;
         return;
      end
      fill_count = 0;
      // row pass
      for (int a = 0; a < 8; a++) begin
         for (int b = 0; b < 8; b++) begin
            acc = 0;
            for (int t = 0; t < 8; t++)
               acc += (inverse_mode ? cos_coef(t, a) : cos_coef(a, t))
                      * longint'(block_mem[t * 8 + b]);
            part[a * 8 + b] = acc;
         end
      end
      // column pass, queued in row-major output order
      for (int a = 0; a < 8; a++) begin
         for (int b = 0; b < 8; b++) begin
            acc = 0;
            for (int t = 0; t < 8; t++)
               acc += part[a * 8 + t] * (inverse_mode ? cos_coef(t, b) : cos_coef(b, t));
            c.value = scale_round(acc);
            c.index = 6'(a * 8 + b);
            c.last = (a * 8 + b == 63);
            coef_queue.insert(coef_queue.size(), c);
         end
      end
      blocks_done++;
   endfunction

   // Mostly back-to-back, sometimes a short gap, now and then a long one.
   function automatic int draw_gap();
      int r;
      if (!idle_enable) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Sample driver: hold the item until taken, then advance.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.sample_value <= '0;
         gap_left <= 0;
      end else begin
         if (req_if.valid && req_if.ready) take_sample(req_if.sample_value);
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_if.valid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
               req_if.valid <= 1'b1;
               req_if.sample_value <= sample_queue.pop_front();
               gap_left <= draw_gap();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: stall ready at random and check each accepted item.
   always @(posedge clock) begin
      coef_item_type exp_c;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (coef_queue.size() == 0) begin
               $display("%0t: unexpected result value %0d index %0d last %0b", $time,
                        rsp_if.result_value, rsp_if.result_index, rsp_if.result_last);
               fail_count++;
            end else begin
               exp_c = coef_queue.pop_front();
               if (rsp_if.result_value !== exp_c.value) begin
                  $display("%0t: value at index %0d expected %0d actual %0d", $time,
                           exp_c.index, exp_c.value, rsp_if.result_value);
                  fail_count++;
               end
               if (rsp_if.result_index !== exp_c.index) begin
                  $display("%0t: index expected %0d actual %0d", $time,
                           exp_c.index, rsp_if.result_index);
                  fail_count++;
               end
               if (rsp_if.result_last !== exp_c.last) begin
                  $display("%0t: last flag at index %0d expected %0b actual %0b", $time,
                           exp_c.index, exp_c.last, rsp_if.result_last);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (rsp_if.valid && rsp_if.ready) stall_left <= draw_gap();
         end
      end
   end

   // Watchdog: count cycles with open work and no item moving on either side.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (sample_queue.size() == 0 && !req_if.valid && coef_queue.size() == 0)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchLimit) begin
            $display("%0t: timeout with %0d results outstanding", $time, coef_queue.size());
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Wait until the core has nothing owed and nothing queued, then settle.
   // Check on the falling edge so the driver's updates have landed.
   task automatic drain();
      while (sample_queue.size() != 0 || req_if.valid || coef_queue.size() != 0)
         @(negedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Write the direction register at an idle point.
   task automatic set_direction(input logic dir);
      drain();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= dir;
      inverse_mode = dir;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_random(input int count, input bit narrow);
      for (int i = 0; i < count; i++) begin
         if (narrow) add_sample(12'($signed($urandom_range(0, 255)) - 128));
         else add_sample(12'($urandom_range(0, 4095)));
      end
   endtask

   initial begin
      fill_count = 0;
      inverse_mode = 1'b0;
      fail_count = 0;
      blocks_done = 0;
      results_seen = 0;
      idle_enable = 1'b0;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Forward block of extremes: full scale, both signs, zero and one.
      set_direction(1'b0);
      for (int i = 0; i < 64; i++) begin
         case (i % 8)
            0: add_sample(12'sd2047);
            1: add_sample(-12'sd2048);
            2: add_sample(12'sd0);
            3: add_sample(-12'sd1);
            4: add_sample(12'sd1);
            default: add_sample((i / 8) % 2 ? -12'sd2048 : 12'sd2047);
         endcase
      end

      // Direction flipped part way through a block: the inverse must apply.
      idle_enable = 1'b1;
      for (int i = 0; i < 20; i++) add_sample(i == 0 ? -12'sd2048 : 12'sd2047);
      set_direction(1'b1);
      for (int i = 0; i < 44; i++) add_sample((i % 3) ? 12'sd2047 : -12'sd2048);

      // Random block, forward, idling on and off.
      for (int blk = 0; blk < 1; blk++) begin
         set_direction(blk[0]);
         idle_enable = $urandom_range(0, 3) != 0;
         push_random(64, $urandom_range(0, 3) == 0);
      end
      set_direction(1'b1);
      push_random(64, 1'b0);
      // Partial block at the end causes no result.
      push_random(14, 1'b0);

      drain();
      $display("Covered %0d transformed blocks and %0d results, both directions.",
               blocks_done, results_seen);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
